// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition must hold in the same cycle as the trigger.
`define RSMP_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);
// Condition must hold in the cycle after the trigger.
`define RSMP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`endif

// ===== rtl/rsmp_pkg.sv =====
// Shared constants, types and coefficient tables of the two-stage resampler.
`timescale 1ns / 1ps
package rsmp_pkg;

    localparam int FIRST_TAPS     = 61;
    localparam int FIRST_DECIM    = 5;
    localparam int INTERP_FACTOR  = 13;
    localparam int DECIM_FACTOR   = 24;
    localparam int TAPS_PER_PHASE = 57;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int ACC_BITS       = 48;
    localparam int S1_HALF        = 31;
    localparam int S1_PROTO       = 61;
    localparam int S2_HALF        = 365;
    localparam int S2_PROTO       = 729;
    localparam int S2_DEPTH       = INTERP_FACTOR * TAPS_PER_PHASE;
    localparam int S1_AW          = $clog2(FIRST_TAPS);
    localparam int S2_AW          = $clog2(S2_DEPTH);

    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef coef_t s1_rom_t [FIRST_TAPS];
    typedef coef_t s2_rom_t [S2_DEPTH];

    typedef struct packed {
        logic clear;
        logic vld;
    } mac_ctrl_t;

    localparam int S1_HALF_D [S1_HALF] = '{
        -31204, -4545, 27904, 68462, 117369, 171261, 222291, 258239, 263792, 222986,
        122527, -44472, -274968, -553362, -850401, -1124041, -1322480, -1389213, -1269630,
        -918414, -306760, 571594, 1696486, 3020315, 4470262, 5953716, 7366408, 8602410,
        9564828, 10175928, 10385425
    };

    localparam int S2_HALF_D [S2_HALF] = '{
        6223, 8348, 10558, 12822, 15103, 17364, 19563, 21657, 23602, 25352,
        26862, 28088, 28987, 29518, 29645, 29335, 28560, 27297, 25530, 23250,
        20457, 17156, 13363, 9102, 4406, -685, -6118, -11837, -17773, -23854,
        -29997, -36117, -42123, -47919, -53408, -58492, -63073, -67054, -70345, -72856,
        -74507, -75225, -74948, -73624, -71213, -67689, -63041, -57275, -50410, -42486,
        -33556, -23693, -12986, -1541, 10521, 23065, 35940, 48986, 62030, 74893,
        87389, 99328, 110520, 120776, 129911, 137746, 144115, 148862, 151848, 152951,
        152070, 149128, 144071, 136874, 127538, 116095, 102608, 87168, 69899, 50954,
        30517, 8797, -13967, -37515, -61564, -85814, -109948, -133640, -156555, -178356,
        -198708, -217281, -233757, -247834, -259230, -267687, -272980, -274914, -273333,
        -268124,
        -259216, -246584, -230256, -210307, -186864, -160106, -130261, -97608, -62475,
        -25231,
        13710, 53898, 94851, 136058, 176987, 217094, 255821, 292613, 326921, 358207,
        385958, 409687, 428946, 443327, 452477, 456097, 453952, 445874, 431768, 411615,
        385475, 353489, 315879, 272948, 225079, 172731, 116439, 56804, -5507, -69772,
        -135221, -201043, -266396, -330420, -392241, -450990, -505810, -555867, -600365,
        -638554,
        -669745, -693318, -708733, -715538, -713383, -702020, -681315, -651250, -611931,
        -563584,
        -506559, -441331, -368495, -288760, -202948, -111983, -16881, 81255, 181253, 281883,
        381869, 479909, 574686, 664889, 749226, 826447, 895353, 954824, 1003823, 1041425,
        1066821, 1079337, 1078447, 1063781, 1035138, 992489, 935985, 865958, 782926, 687585,
        580809, 463646, 337303, 203138, 62649, -82545, -230721, -380069, -528715, -674743,
        -816217, -951208, -1077816, -1194198, -1298589, -1389331, -1464896, -1523907,
        -1565160, -1587648,
        -1590574, -1573368, -1535704, -1477506, -1398957, -1300505, -1182863, -1047007,
        -894172, -725840,
        -543732, -349788, -146152, 64853, 280748, 498923, 716673, 931224, 1139769, 1339500,
        1527647, 1701514, 1858509, 1996189, 2112285, 2204744, 2271754, 2311775, 2323569,
        2306220,
        2259153, 2182153, 2075379, 1939366, 1775034, 1583683, 1366988, 1126989, 866075,
        586962,
        292669, -13512, -328049, -647209, -967096, -1283700, -1592941, -1890715, -2172949,
        -2435652,
        -2674963, -2887205, -3068936, -3216995, -3328555, -3401158, -3432764, -3421783,
        -3367109, -3268145,
        -3124827, -2937639, -2707622, -2436378, -2126065, -1779388, -1399582, -990387,
        -556016, -101120,
        369256, 849721, 1334598, 1817979, 2293788, 2755853, 3197977, 3614006, 3997908,
        4343847,
        4646260, 4899927, 5100048, 5242308, 5322946, 5338817, 5287443, 5167070, 4976706,
        4716159,
        4386067, 3987915, 3524046, 2997665, 2412829, 1774434, 1088181, 360548, -401259,
        -1189360,
        -1995265, -2809939, -3623888, -4427239, -5209830, -5961309, -6671236, -7329178,
        -7924826, -8448092,
        -8889222, -9238899, -9488349, -9629439, -9654773, -9557785, -9332819, -8975211,
        -8481352, -7848750,
        -7076078, -6163212, -5111262, -3922583, -2600783, -1150713, 421551, 2108744,
        3902451, 5793165,
        7770356, 9822543, 11937385, 14101777, 16301956, 18523608, 20751995, 22972070,
        25168610, 27326347,
        29430098, 31464897, 33416129, 35269658, 37011953, 38630207, 40112455, 41447680,
        42625912, 43638319,
        44477288, 45136492, 45610949, 45897070, 45992685
    };

    // Decimal 1e-8 units to Q1.17, ties away from zero.
    function automatic coef_t to_q17(int d);
        longint m;
        longint q;
        m = (d < 0) ? -longint'(d) : longint'(d);
        q = (m * 131072 + 50000000) / 100000000;
        return (d < 0) ? coef_t'(-q) : coef_t'(q);
    endfunction

    function automatic s1_rom_t build_s1();
        s1_rom_t rom;
        int h;
        for (int t = 0; t < FIRST_TAPS; t++) begin
            h = (t < S1_HALF) ? t : (S1_PROTO - 1 - t);
            rom[t] = (t < S1_PROTO && h < S1_HALF) ? to_q17(S1_HALF_D[h]) : coef_t'(0);
        end
        return rom;
    endfunction

    function automatic s2_rom_t build_s2();
        s2_rom_t rom;
        int k;
        int h;
        for (int p = 0; p < INTERP_FACTOR; p++) begin
            for (int t = 0; t < TAPS_PER_PHASE; t++) begin
                k = p + INTERP_FACTOR * t;
                h = (k < S2_HALF) ? k : (S2_PROTO - 1 - k);
                rom[p * TAPS_PER_PHASE + t] = (k < S2_PROTO && h >= 0 && h < S2_HALF) ?
                    to_q17(S2_HALF_D[h]) : coef_t'(0);
            end
        end
        return rom;
    endfunction

    localparam s1_rom_t S1_ROM = build_s1();
    localparam s2_rom_t S2_ROM = build_s2();

endpackage

// ===== rtl/rsmp_hist_ram.sv =====
// Sample history memory: one write port, one registered read port, zero until written.
`timescale 1ns / 1ps
module rsmp_hist_ram #(
    parameter int DEPTH = rsmp_pkg::FIRST_TAPS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    import rsmp_pkg::*;

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [31:0]      rd_raw_reg;
    logic             rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_ok_reg ? rd_raw_reg : 32'd0;

endmodule

// ===== rtl/rsmp_coef_rom.sv =====
// Coefficient tables of both stages with a registered read.
`timescale 1ns / 1ps
module rsmp_coef_rom (
    input  logic                        clk,
    input  logic                        sel_s2,
    input  logic [rsmp_pkg::S1_AW-1:0]  addr_s1,
    input  logic [rsmp_pkg::S2_AW-1:0]  addr_s2,
    output rsmp_pkg::coef_t             coef
);
    import rsmp_pkg::*;

    coef_t coef_reg;

    always_ff @(posedge clk)
    begin
        coef_reg <= sel_s2 ? S2_ROM[addr_s2] : S1_ROM[addr_s1];
    end

    assign coef = coef_reg;

endmodule

// ===== rtl/rsmp_mac.sv =====
// Complex multiply-accumulate pipeline: product register then accumulator.
`timescale 1ns / 1ps
module rsmp_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  rsmp_pkg::mac_ctrl_t ctrl,
    input  rsmp_pkg::coef_t     coef,
    input  rsmp_pkg::smp_t      smp_i,
    input  rsmp_pkg::smp_t      smp_q,
    output logic                busy,
    output rsmp_pkg::acc_t      acc_i,
    output rsmp_pkg::acc_t      acc_q
);
    import rsmp_pkg::*;

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;

    logic signed [PROD_BITS-1:0] prod_i_reg, prod_q_reg;
    logic                        prod_vld_reg;
    acc_t                        acc_i_reg, acc_q_reg;

    always_ff @(posedge clk)
    begin
        prod_i_reg <= coef * smp_i;
        prod_q_reg <= coef * smp_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_i_reg    <= '0;
            acc_q_reg    <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.vld;
            if (ctrl.clear)
            begin
                acc_i_reg <= '0;
                acc_q_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_i_reg <= acc_i_reg + ACC_BITS'(prod_i_reg);
                acc_q_reg <= acc_q_reg + ACC_BITS'(prod_q_reg);
            end
        end
    end

    assign busy  = prod_vld_reg;
    assign acc_i = acc_i_reg;
    assign acc_q = acc_q_reg;

endmodule

// ===== rtl/two_stage_polyphase_resampler_top.sv =====
// An input that ends no decimation period is accepted without stalling; the fifth input
// starts the 61-tap stage, followed by a 57-tap branch when one is due.
// Both stages are served by the single shared complex MAC, which walks both history
// memories one tap per cycle. Input stalls while busy.
// Reset: asynchronous, active low; histories read as zero, counters and phase clear.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_stage_polyphase_resampler_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rsmp_pkg::smp_t        in_i,
    input  rsmp_pkg::smp_t        in_q,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsmp_pkg::smp_t        out_i,
    output rsmp_pkg::smp_t        out_q
);
    import rsmp_pkg::*;

    localparam int H1_AW = $clog2(FIRST_TAPS);
    localparam int H2_AW = $clog2(TAPS_PER_PHASE);
    localparam int CNT_W = $clog2(FIRST_TAPS + 3);
    localparam int DC_W  = $clog2(FIRST_DECIM + 1);
    localparam int PH_W  = $clog2(INTERP_FACTOR + DECIM_FACTOR + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_S1   = 2'd1;
    localparam logic [1:0] ST_S2   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [H1_AW-1:0] wp1_reg, wp1_next, rp1_reg, rp1_next;
    logic [H2_AW-1:0] wp2_reg, wp2_next, rp2_reg, rp2_next;
    logic [DC_W-1:0]  dc_reg, dc_next;
    logic [PH_W-1:0]  phase_reg, phase_next, phase_up;
    logic [S2_AW-1:0] base_reg, base_next;
    logic             iss_reg;
    smp_t             out_i_reg, out_i_next, out_q_reg, out_q_next;
    logic             out_vld_reg, out_vld_next;

    logic             in_xfer, issue, mac_clear, h2_wr, out_load, s1_end, s2_end;
    logic [31:0]      h1_rd, h2_rd;
    smp_t             s_i, s_q, y_i, y_q, m_i, m_q;
    coef_t            coef;
    acc_t             acc_i, acc_q;
    mac_ctrl_t        mac_ctrl;
    logic             mac_busy;

    function automatic smp_t round_sat(acc_t a);
        logic signed [ACC_BITS:0] r;
        logic signed [ACC_BITS:0] v;
        r = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(65536);
        v = r >>> 17;
        if (v > (ACC_BITS+1)'(32767))
        begin
            return smp_t'(16'sh7fff);
        end
        if (v < -(ACC_BITS+1)'(32768))
        begin
            return smp_t'(16'sh8000);
        end
        return smp_t'(v);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign issue    = (state_reg != ST_IDLE) && (cnt_reg < CNT_W'(
                      (state_reg == ST_S1) ? FIRST_TAPS : TAPS_PER_PHASE));
    assign s1_end   = (state_reg == ST_S1) && (cnt_reg == CNT_W'(FIRST_TAPS + 2));
    assign s2_end   = (state_reg == ST_S2) && (cnt_reg == CNT_W'(TAPS_PER_PHASE + 2));
    assign out_load = s2_end && (!out_vld_reg || !out_stall);

    assign s_i = round_sat(acc_i);
    assign s_q = round_sat(acc_q);
    assign y_i = s_i;
    assign y_q = s_q;
    assign h2_wr = s1_end;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        wp1_next     = wp1_reg;
        rp1_next     = rp1_reg;
        wp2_next     = wp2_reg;
        rp2_next     = rp2_reg;
        dc_next      = dc_reg;
        phase_next   = phase_reg;
        base_next    = base_reg;
        out_i_next   = out_i_reg;
        out_q_next   = out_q_reg;
        out_vld_next = out_vld_reg && out_stall;
        mac_clear    = 1'b0;
        phase_up     = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    wp1_next = (wp1_reg == H1_AW'(FIRST_TAPS - 1)) ? '0 : wp1_reg + 1'b1;
                    if (dc_reg == DC_W'(FIRST_DECIM - 1))
                    begin
                        dc_next    = '0;
                        rp1_next   = wp1_reg;
                        cnt_next   = '0;
                        mac_clear  = 1'b1;
                        state_next = ST_S1;
                    end
                    else
                    begin
                        dc_next = dc_reg + 1'b1;
                    end
                end
            end
            ST_S1:
            begin
                if (issue)
                begin
                    rp1_next = (rp1_reg == '0) ? H1_AW'(FIRST_TAPS - 1) : rp1_reg - 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!s1_end)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    wp2_next = (wp2_reg == H2_AW'(TAPS_PER_PHASE - 1)) ? '0 : wp2_reg + 1'b1;
                    rp2_next = wp2_reg;
                    cnt_next = '0;
                    if (phase_reg < PH_W'(INTERP_FACTOR))
                    begin
                        phase_up   = phase_reg + PH_W'(DECIM_FACTOR);
                        base_next  = S2_AW'(phase_reg) * S2_AW'(TAPS_PER_PHASE);
                        mac_clear  = 1'b1;
                        state_next = ST_S2;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                    phase_next = (phase_up >= PH_W'(INTERP_FACTOR)) ?
                                 phase_up - PH_W'(INTERP_FACTOR) : '0;
                end
            end
            ST_S2:
            begin
                if (issue)
                begin
                    rp2_next = (rp2_reg == '0) ? H2_AW'(TAPS_PER_PHASE - 1) : rp2_reg - 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!s2_end)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_load)
                begin
                    out_i_next   = y_i;
                    out_q_next   = y_q;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wp1_reg     <= '0;
            rp1_reg     <= '0;
            wp2_reg     <= '0;
            rp2_reg     <= '0;
            dc_reg      <= '0;
            phase_reg   <= '0;
            base_reg    <= '0;
            iss_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wp1_reg     <= wp1_next;
            rp1_reg     <= rp1_next;
            wp2_reg     <= wp2_next;
            rp2_reg     <= rp2_next;
            dc_reg      <= dc_next;
            phase_reg   <= phase_next;
            base_reg    <= base_next;
            iss_reg     <= issue;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_i_reg <= out_i_next;
        out_q_reg <= out_q_next;
    end

    rsmp_hist_ram #(
        .DEPTH (FIRST_TAPS)
    ) u_hist1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer),
        .wr_addr (wp1_reg),
        .wr_data ({in_i, in_q}),
        .rd_addr (rp1_reg),
        .rd_data (h1_rd)
    );

    rsmp_hist_ram #(
        .DEPTH (TAPS_PER_PHASE)
    ) u_hist2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (h2_wr),
        .wr_addr (wp2_reg),
        .wr_data ({s_i, s_q}),
        .rd_addr (rp2_reg),
        .rd_data (h2_rd)
    );

    rsmp_coef_rom u_rom (
        .clk     (clk),
        .sel_s2  (state_reg == ST_S2),
        .addr_s1 (cnt_reg),
        .addr_s2 (base_reg + S2_AW'(cnt_reg)),
        .coef    (coef)
    );

    assign m_i = (state_reg == ST_S2) ? smp_t'(h2_rd[31:16]) : smp_t'(h1_rd[31:16]);
    assign m_q = (state_reg == ST_S2) ? smp_t'(h2_rd[15:0])  : smp_t'(h1_rd[15:0]);

    assign mac_ctrl.clear = mac_clear;
    assign mac_ctrl.vld   = iss_reg;

    rsmp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (coef),
        .smp_i (m_i),
        .smp_q (m_q),
        .busy  (mac_busy),
        .acc_i (acc_i),
        .acc_q (acc_q)
    );

    assign out_valid = out_vld_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    `RSMP_ASSERT_NOW(a_phase_range, 1'b1, phase_reg < PH_W'(DECIM_FACTOR), "phase out of range")
    `RSMP_ASSERT_NOW(a_decim_range, 1'b1, dc_reg < DC_W'(FIRST_DECIM), "decim count out of range")
    `RSMP_ASSERT_NOW(a_idle_mac, state_reg == ST_IDLE, !mac_busy && !iss_reg, "MAC busy while idle")
    `RSMP_ASSERT_NEXT(a_load_valid, out_load, out_vld_reg, "result transfer not presented")

endmodule
